// ===== hw/rtl/rxmbh_pkg.sv =====
// Constants and mixing functions for the rotate-xor-multiply buffer hash.
package rxmbh_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned CountWidth = 3;

  localparam logic [WordWidth-1:0] GoldenMult = 32'h9e37_79b9;
  localparam int unsigned          RotLeft    = 5;
  localparam int unsigned          RotRight   = 27;

  localparam logic [CountWidth-1:0] CountNone  = 3'd0;
  localparam logic [CountWidth-1:0] CountOne   = 3'd1;
  localparam logic [CountWidth-1:0] CountTwo   = 3'd2;
  localparam logic [CountWidth-1:0] CountThree = 3'd3;

  typedef logic [WordWidth-1:0] word_t;

  // Rotate left, xor in the word, multiply by the golden-ratio constant mod 2^32.
  function automatic word_t mix_word(word_t acc, word_t w);
    word_t rot;
    rot = (acc << RotLeft) | (acc >> RotRight);
    return word_t'((rot ^ w) * GoldenMult);
  endfunction

  // Tail bytes packed first byte most significant.
  function automatic word_t pack_tail(word_t w, logic [CountWidth-1:0] count);
    word_t packed_w;
    unique case (count)
      CountOne:   packed_w = {24'd0, w[7:0]};
      CountTwo:   packed_w = {16'd0, w[7:0], w[15:8]};
      CountThree: packed_w = {8'd0, w[7:0], w[15:8], w[23:16]};
      default:    packed_w = w;
    endcase
    return packed_w;
  endfunction

endpackage

// ===== hw/rtl/rotate_xor_multiply_buffer_hash_top.sv =====
// Top level of the rotate-xor-multiply buffer hash.
//
// Usage:
//   A buffer arrives on the input channel (in_valid/in_ready) as a stream of
//   32-bit little-endian words, first byte in bits 7:0. valid_bytes gives
//   the bytes used in the word (4 for full words, 0..3 on the final word);
//   last_word marks the final word of the buffer.
//   Each word is mixed into the running hash in the cycle it is accepted.
//   On the final word the finished hash goes to the output register, or to
//   the skid register while the output register holds an untaken result;
//   the running hash then restarts at zero. An empty buffer hashes to zero.
//   Throughput: one word per cycle while in_ready is high; the rotate, xor
//   and 32x32 multiply are combinational, feeding the running hash register.
//   A two-entry output stage (output register plus skid register) keeps
//   input words flowing while a result waits; in_ready drops only when both
//   entries hold results the receiver has not taken.
//   Reset (rst, synchronous) clears the running hash and empties the output.
module rotate_xor_multiply_buffer_hash_top
  import rxmbh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [WordWidth-1:0]  data_word,
  input  logic [CountWidth-1:0] valid_bytes,
  input  logic                  last_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [WordWidth-1:0]  hash_value
);

  word_t running_hash;
  word_t running_hash_next;
  word_t mixed;
  word_t skid_hash;
  logic  skid_valid;
  logic  in_fire;
  logic  push;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign push     = in_fire && last_word;

  always_comb begin
    if (valid_bytes == CountNone) begin
      mixed = running_hash;
    end else begin
      mixed = mix_word(running_hash, pack_tail(data_word, valid_bytes));
    end
  end

  always_comb begin
    running_hash_next = running_hash;
    if (in_fire) begin
      running_hash_next = last_word ? '0 : mixed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
    end else begin
      running_hash <= running_hash_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        hash_value <= skid_hash;
      end else if (push) begin
        hash_value <= mixed;
      end
    end else if (push) begin
      skid_hash <= mixed;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    push |=> running_hash == '0)
    else $error("running hash not cleared after last word");

  a_empty_word_keeps: assert property (@(posedge clk) disable iff (rst)
    in_fire && !last_word && valid_bytes == CountNone |=> $stable(running_hash))
    else $error("running hash changed on a word with no bytes");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready && push))
    else $error("skid register filled without a stalled result");

endmodule
